@@ design/cbdq_pkg.sv @@
// Shared types and constants for the circular buffer deque.
package cbdq_pkg;

   localparam int DEPTH_DEFAULT      = 256;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int WORD_WIDTH         = 32;
   localparam int COUNT_WIDTH        = 9;
   localparam int CSR_ADDR_WIDTH     = 3;
   localparam int CSR_DATA_WIDTH     = 32;

   localparam logic [COUNT_WIDTH-1:0] CAPACITY_RESET = 9'd256;

   // register select is byte address bit 2
   localparam logic CSR_CAPACITY = 1'b0;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      op_type                        op;
      logic signed [WORD_WIDTH-1:0]  push_value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_WIDTH-1:0]  read_value;
      status_type                    status;
      logic [COUNT_WIDTH-1:0]        element_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic push;
      logic take;
      logic at_back;
      logic remove;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic empty;
   } dp_stat_type;

endpackage

@@ design/cbdq_ctrl.sv @@
// Request decode and reply sequencing for the circular buffer deque.
module cbdq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  cbdq_pkg::op_type       op,
   input  cbdq_pkg::dp_stat_type  dp_stat,
   output cbdq_pkg::dp_cmd_type   dp_cmd,
   output logic                   busy,
   output logic                   rsp_strobe,
   output cbdq_pkg::status_type   rsp_status
);
   import cbdq_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_REPLY
   } state_type;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;
   logic       accept;

   assign accept = start && (state_ff == S_IDLE);

   always_comb begin
      dp_cmd    = '0;
      status_in = ST_OK;
      state_in  = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_REPLY;
               case (op)
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     if (dp_stat.full) begin
                        status_in = ST_FULL;
                     end else begin
                        dp_cmd.push    = 1'b1;
                        dp_cmd.at_back = (op == OP_PUSH_BACK);
                     end
                  end
                  OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
                     if (dp_stat.empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        dp_cmd.take    = 1'b1;
                        dp_cmd.at_back = (op == OP_POP_BACK) || (op == OP_PEEK_BACK);
                        dp_cmd.remove  = (op == OP_POP_FRONT) || (op == OP_POP_BACK);
                     end
                  end
                  default: begin
                     // unknown codes answer ok and touch nothing
                     status_in = ST_OK;
                  end
               endcase
            end
         end
         S_REPLY: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= ST_OK;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            status_ff <= status_in;
         end
      end
   end

   assign busy       = (state_ff == S_REPLY);
   assign rsp_strobe = (state_ff == S_REPLY);
   assign rsp_status = status_ff;

endmodule

@@ design/cbdq_datapath.sv @@
// Element store, front index and count for the circular buffer deque.
module cbdq_datapath #(
   parameter int DEPTH      = cbdq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = cbdq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     clear,
   input  logic [cbdq_pkg::COUNT_WIDTH-1:0]         capacity,
   input  logic signed [cbdq_pkg::WORD_WIDTH-1:0]   push_value,
   input  cbdq_pkg::dp_cmd_type                     dp_cmd,
   output cbdq_pkg::dp_stat_type                    dp_stat,
   output logic signed [cbdq_pkg::WORD_WIDTH-1:0]   read_value,
   output logic [cbdq_pkg::COUNT_WIDTH-1:0]         element_count
);
   import cbdq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int SUM_W = ((IDX_W > COUNT_WIDTH) ? IDX_W : COUNT_WIDTH) + 1;

   function automatic logic [SUM_W-1:0] wrap_up(input logic [SUM_W-1:0] base,
                                                input logic [SUM_W-1:0] add,
                                                input logic [SUM_W-1:0] cap);
      logic [SUM_W-1:0] s;
      s = base + add;
      if (s >= cap) begin
         s = s - cap;
      end
      return s;
   endfunction

   logic [DATA_WIDTH-1:0]   mem [DEPTH];
   logic [DATA_WIDTH-1:0]   rdata_ff;
   logic                    show_ff;
   logic [IDX_W-1:0]        front_ff, front_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;

   logic [COUNT_WIDTH-1:0]  cap_eff;
   logic [SUM_W-1:0]        cap_ext, front_ext, cnt_ext;
   logic [SUM_W-1:0]        new_front, back_push, back_read, front_pop;
   logic [SUM_W-1:0]        wr_pos, rd_pos;
   logic [DATA_WIDTH-1:0]   wdata;
   logic [DATA_WIDTH+WORD_WIDTH-1:0] wr_ext, rd_ext;

   // zero acts as one, anything above the store depth acts as the depth
   always_comb begin
      if (capacity == '0) begin
         cap_eff = COUNT_WIDTH'(1);
      end else if (SUM_W'(capacity) > SUM_W'(DEPTH)) begin
         cap_eff = COUNT_WIDTH'(DEPTH);
      end else begin
         cap_eff = capacity;
      end
   end

   assign cap_ext   = SUM_W'(cap_eff);
   assign front_ext = SUM_W'(front_ff);
   assign cnt_ext   = SUM_W'(count_ff);

   assign new_front = (front_ff == '0) ? cap_ext - SUM_W'(1) : front_ext - SUM_W'(1);
   assign back_push = wrap_up(front_ext, cnt_ext, cap_ext);
   assign back_read = wrap_up(front_ext, cnt_ext - SUM_W'(1), cap_ext);
   assign front_pop = wrap_up(front_ext, SUM_W'(1), cap_ext);

   assign wr_pos = dp_cmd.at_back ? back_push : new_front;
   assign rd_pos = dp_cmd.at_back ? back_read : front_ext;

   assign wr_ext = {{DATA_WIDTH{1'b0}}, push_value};
   assign wdata  = wr_ext[DATA_WIDTH-1:0];

   assign dp_stat.full  = (count_ff >= cap_eff);
   assign dp_stat.empty = (count_ff == '0);

   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      if (clear) begin
         front_in = '0;
         count_in = '0;
      end else if (dp_cmd.push) begin
         count_in = count_ff + COUNT_WIDTH'(1);
         if (!dp_cmd.at_back) begin
            front_in = new_front[IDX_W-1:0];
         end
      end else if (dp_cmd.take && dp_cmd.remove) begin
         count_in = count_ff - COUNT_WIDTH'(1);
         if (!dp_cmd.at_back) begin
            front_in = front_pop[IDX_W-1:0];
         end
      end
   end

   // read data shows only in the reply cycle of a successful pop or peek
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
         show_ff  <= 1'b0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
         show_ff  <= dp_cmd.take;
      end
   end

   // element store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (dp_cmd.push) begin
         mem[wr_pos[IDX_W-1:0]] <= wdata;
      end
      if (dp_cmd.take) begin
         rdata_ff <= mem[rd_pos[IDX_W-1:0]];
      end
   end

   assign rd_ext        = {{WORD_WIDTH{1'b0}}, rdata_ff};
   assign read_value    = show_ff ? signed'(rd_ext[WORD_WIDTH-1:0]) : '0;
   assign element_count = count_ff;

endmodule

@@ design/circular_buffer_deque_core.sv @@
// Double-ended queue over a circular element store, with APB capacity register.
//
// Each request is accepted when start is high and busy low; the store is written or
// read at that edge, and the result is on rsp_data for the following cycle, marked
// by rsp_valid, while busy is high. The data comes from the registered read port
// of the element store, and the status is registered alongside it. The receiver
// cannot stall; it must take each result in its strobe cycle. Pushes into a
// full queue answer status full, pops and peeks on an empty queue answer status
// empty with zero data; unknown op codes answer ok and change nothing. Writing
// the capacity register (address 0) empties the queue; write it only while idle.
// A capacity of zero behaves as one, above DEPTH as DEPTH. No clearing pass
// runs after reset.
module circular_buffer_deque_core #(
   parameter int DEPTH      = cbdq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = cbdq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  cbdq_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   output cbdq_pkg::rsp_type                     rsp_data,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [cbdq_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [cbdq_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [cbdq_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                  pready
);
   import cbdq_pkg::*;

   logic [COUNT_WIDTH-1:0] capacity_ff;
   logic                   cap_write;
   dp_cmd_type             dp_cmd;
   dp_stat_type            dp_stat;
   status_type             rsp_status;
   logic signed [WORD_WIDTH-1:0] read_value;
   logic [COUNT_WIDTH-1:0] element_count;

   assign pready    = 1'b1;
   assign cap_write = psel && penable && pwrite && pready && (paddr[2] == CSR_CAPACITY);
   assign prdata    = (paddr[2] == CSR_CAPACITY) ? CSR_DATA_WIDTH'(capacity_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (cap_write) begin
         capacity_ff <= pwdata[COUNT_WIDTH-1:0];
      end
   end

   cbdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .op         (req_data.op),
      .dp_stat    (dp_stat),
      .dp_cmd     (dp_cmd),
      .busy       (busy),
      .rsp_strobe (rsp_valid),
      .rsp_status (rsp_status)
   );

   cbdq_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .clear         (cap_write),
      .capacity      (capacity_ff),
      .push_value    (req_data.push_value),
      .dp_cmd        (dp_cmd),
      .dp_stat       (dp_stat),
      .read_value    (read_value),
      .element_count (element_count)
   );

   assign rsp_data.read_value    = read_value;
   assign rsp_data.status        = rsp_status;
   assign rsp_data.element_count = element_count;

   // every accepted word gets its reply in the next cycle
   a_reply_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("accepted word got no reply");

   // a reply lasts one cycle
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("reply strobe held longer than one cycle");

   // refused requests leave the count alone
   a_refused_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == ST_FULL || rsp_data.status == ST_EMPTY))
         |-> (rsp_data.element_count == $past(rsp_data.element_count)))
      else $error("refused request changed the count");

   // empty refusals carry zero data
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_EMPTY) |-> (rsp_data.read_value == '0))
      else $error("empty refusal returned data");

endmodule
